/* rtl/core/adc_block_trimmed_mean_core_assert.svh */
// Assertion macros shared by the trimmed-mean filter RTL.
`ifndef ADC_BLOCK_TRIMMED_MEAN_CORE_ASSERT_SVH
`define ADC_BLOCK_TRIMMED_MEAN_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ABTM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("abtm: assertion failed");
// Next-cycle implication, disabled during reset.
`define ABTM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("abtm: assertion failed");
`else
`define ABTM_ASSERT_IMP(label, clk, rstn, ante, cons)
`define ABTM_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

/* rtl/core/abtm_pkg.sv */
// Package: constants, state and handshake types of the trimmed-mean filter.
`default_nettype none

package abtm_pkg;

    localparam int WINDOW   = 20;
    localparam int CHANNELS = 4;
    localparam int HALF_WIN = WINDOW / 2;

    localparam int SAMPLE_W = 12;
    localparam int CHAN_W   = 2;
    localparam int SKIP_W   = 4;
    localparam logic [SKIP_W-1:0] SKIP_RESET = 4'd5;

    localparam int POS_W    = $clog2(WINDOW);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RAM_DEPTH = CHANNELS * WINDOW;
    localparam int ADDR_W   = $clog2(RAM_DEPTH);
    localparam int SUM_W    = SAMPLE_W + $clog2(HALF_WIN);
    // Divide by HALF_WIN as a multiply by a rounded-up reciprocal and a shift;
    // exact for every SUM_W-bit sum
    localparam int DIV_SHIFT = SUM_W + $clog2(HALF_WIN);
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** DIV_SHIFT + HALF_WIN - 1) / HALF_WIN);
    localparam int STEP_MAX = WINDOW + 1;
    localparam int STEP_W   = $clog2(STEP_MAX + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_LOAD,
        ST_SORT,
        ST_SUM,
        ST_DIV,
        ST_UPDATE,
        ST_RESULT
    } abtm_state_t;

    typedef struct packed {
        logic accept;
        logic write;
        logic load;
        logic sort;
        logic sum;
        logic div;
        logic step_clr;
        logic finish;
        logic out_load;
    } abtm_cmd_t;

    typedef struct packed {
        logic chan_ok;
        logic block_full;
        logic step_last;
        logic out_free;
    } abtm_status_t;

endpackage

`default_nettype wire

/* rtl/core/abtm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module abtm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 80
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/abtm_ctrl.sv */
// Controller state machine of the trimmed-mean filter.
`default_nettype none

module abtm_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire abtm_pkg::abtm_status_t status,
    output abtm_pkg::abtm_cmd_t         cmd
);

    abtm_pkg::abtm_state_t state_reg;
    abtm_pkg::abtm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= abtm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            abtm_pkg::ST_IDLE: begin
                if (s_valid) state_next = abtm_pkg::ST_WRITE;
            end
            abtm_pkg::ST_WRITE: begin
                if (status.chan_ok && status.block_full) state_next = abtm_pkg::ST_LOAD;
                else                                     state_next = abtm_pkg::ST_RESULT;
            end
            abtm_pkg::ST_LOAD: begin
                if (status.step_last) state_next = abtm_pkg::ST_SORT;
            end
            abtm_pkg::ST_SORT: begin
                if (status.step_last) state_next = abtm_pkg::ST_SUM;
            end
            abtm_pkg::ST_SUM: begin
                if (status.step_last) state_next = abtm_pkg::ST_DIV;
            end
            abtm_pkg::ST_DIV: begin
                if (status.step_last) state_next = abtm_pkg::ST_UPDATE;
            end
            abtm_pkg::ST_UPDATE: begin
                state_next = abtm_pkg::ST_RESULT;
            end
            abtm_pkg::ST_RESULT: begin
                if (status.out_free) state_next = abtm_pkg::ST_IDLE;
            end
            default: state_next = abtm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            abtm_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            abtm_pkg::ST_WRITE: begin
                cmd.write    = 1'b1;
                cmd.step_clr = 1'b1;
            end
            abtm_pkg::ST_LOAD: begin
                cmd.load     = 1'b1;
                cmd.step_clr = status.step_last;
            end
            abtm_pkg::ST_SORT: begin
                cmd.sort     = 1'b1;
                cmd.step_clr = status.step_last;
            end
            abtm_pkg::ST_SUM: begin
                cmd.sum      = 1'b1;
                cmd.step_clr = status.step_last;
            end
            abtm_pkg::ST_DIV: begin
                cmd.div = 1'b1;
            end
            abtm_pkg::ST_UPDATE: begin
                cmd.finish = 1'b1;
            end
            abtm_pkg::ST_RESULT: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/abtm_datapath.sv */
// Datapath: sample store, sort row, windowed sum, divider and output register.
`default_nettype none
`include "adc_block_trimmed_mean_core_assert.svh"

module abtm_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire abtm_pkg::abtm_cmd_t                cmd,
    output abtm_pkg::abtm_status_t                  status,
    input  wire logic [abtm_pkg::SKIP_W-1:0]        skip_low,
    input  wire logic [abtm_pkg::CHAN_W-1:0]        s_channel,
    input  wire logic [abtm_pkg::SAMPLE_W-1:0]      s_sample,
    input  wire logic                              m_ready,
    output logic                                   m_valid,
    output logic      [abtm_pkg::SAMPLE_W-1:0]      m_average
);

    localparam int SW = abtm_pkg::SAMPLE_W;
    localparam int W  = abtm_pkg::WINDOW;

    // Latched item
    logic [abtm_pkg::CHAN_W-1:0] ch_reg;
    logic [SW-1:0]               smp_reg;
    logic                        chan_ok_reg;

    // Per-channel control state
    logic [abtm_pkg::POS_W-1:0] fill_reg [abtm_pkg::CHANNELS];
    logic [SW-1:0]              held_reg [abtm_pkg::CHANNELS];

    // Block processing
    logic [SW-1:0]                  arr_reg  [W];
    logic [SW-1:0]                  arr_next [W];
    logic [abtm_pkg::STEP_W-1:0]    step_reg;
    logic                           rd_valid_reg;
    logic [abtm_pkg::SUM_W-1:0]     sum_reg;
    logic [abtm_pkg::SUM_W-1:0]     sum_next;

    // Output register
    logic          m_valid_reg;
    logic [SW-1:0] m_average_reg;

    logic [abtm_pkg::CH_IDX_W-1:0] ch_idx;
    logic [abtm_pkg::POS_W-1:0]    pos;
    logic                          pos_last;
    logic [abtm_pkg::ADDR_W-1:0]   wr_addr;
    logic [abtm_pkg::ADDR_W-1:0]   rd_addr;
    logic                          wr_en;
    logic                          rd_en;
    logic [SW-1:0]                 rd_data;
    logic [abtm_pkg::STEP_W-1:0]   start;
    logic                          in_band;
    logic [abtm_pkg::PROD_W-1:0]   quot_prod;
    int                            step_limit;

    assign ch_idx   = abtm_pkg::CH_IDX_W'(ch_reg);
    assign pos      = fill_reg[ch_idx];
    assign pos_last = (32'(pos) == W - 1);

    assign wr_en   = cmd.write && chan_ok_reg;
    assign wr_addr = abtm_pkg::ADDR_W'(32'(ch_idx) * W + 32'(pos));
    assign rd_en   = cmd.load && (32'(step_reg) < W);
    assign rd_addr = abtm_pkg::ADDR_W'(32'(ch_idx) * W + 32'(step_reg));

    abtm_ram #(
        .WIDTH (SW),
        .DEPTH (abtm_pkg::RAM_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (smp_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Saturate the skip so the summed band stays inside the block
    assign start = (32'(skip_low) > W - abtm_pkg::HALF_WIN)
                 ? abtm_pkg::STEP_W'(W - abtm_pkg::HALF_WIN)
                 : abtm_pkg::STEP_W'(skip_low);
    assign in_band = (step_reg >= start)
                  && (32'(step_reg) < 32'(start) + abtm_pkg::HALF_WIN);

    // Quotient of the band sum by HALF_WIN: reciprocal multiply, then shift
    assign quot_prod = abtm_pkg::PROD_W'(sum_reg) * abtm_pkg::PROD_W'(abtm_pkg::RECIP);

    always_comb begin
        priority if (cmd.load)             step_limit = W;
        else if (cmd.sort || cmd.sum)      step_limit = W - 1;
        else                               step_limit = 0;
    end

    assign status.chan_ok    = chan_ok_reg;
    assign status.block_full = pos_last;
    assign status.step_last  = (32'(step_reg) == step_limit);
    assign status.out_free   = !m_valid_reg || m_ready;

    // Sort row: shift in on load, odd-even exchange on sort, shift down on sum
    always_comb begin
        arr_next = arr_reg;
        priority if (rd_valid_reg) begin
            for (int j = 0; j < W - 1; j++) begin
                arr_next[j] = arr_reg[j+1];
            end
            arr_next[W-1] = rd_data;
        end else if (cmd.sort) begin
            for (int j = 0; j < W - 1; j++) begin
                if (((j % 2) == int'(step_reg[0])) && (arr_reg[j] > arr_reg[j+1])) begin
                    arr_next[j]   = arr_reg[j+1];
                    arr_next[j+1] = arr_reg[j];
                end
            end
        end else if (cmd.sum) begin
            for (int j = 0; j < W - 1; j++) begin
                arr_next[j] = arr_reg[j+1];
            end
        end else begin
            arr_next = arr_reg;
        end
    end

    // Accumulate the band, then replace the sum by its quotient in one step
    always_comb begin
        sum_next = sum_reg;
        priority if (cmd.load) begin
            sum_next = '0;
        end else if (cmd.sum) begin
            if (in_band) sum_next = sum_reg + abtm_pkg::SUM_W'(arr_reg[0]);
        end else if (cmd.div) begin
            sum_next = abtm_pkg::SUM_W'(quot_prod >> abtm_pkg::DIV_SHIFT);
        end else begin
            sum_next = sum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ch_reg  <= s_channel;
            smp_reg <= s_sample;
        end
        arr_reg <= arr_next;
        sum_reg <= sum_next;
        if (cmd.out_load) begin
            m_average_reg <= chan_ok_reg ? held_reg[ch_idx] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_ok_reg  <= 1'b0;
            step_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int c = 0; c < abtm_pkg::CHANNELS; c++) begin
                fill_reg[c] <= '0;
                held_reg[c] <= '0;
            end
        end else begin
            if (cmd.accept) begin
                chan_ok_reg <= (32'(s_channel) < abtm_pkg::CHANNELS);
            end
            if (cmd.step_clr) begin
                step_reg <= '0;
            end else if (cmd.load || cmd.sort || cmd.sum || cmd.div) begin
                step_reg <= step_reg + 1'b1;
            end
            rd_valid_reg <= rd_en;
            if (wr_en) begin
                fill_reg[ch_idx] <= pos_last ? '0 : pos + 1'b1;
            end
            if (cmd.finish && chan_ok_reg) begin
                held_reg[ch_idx] <= sum_reg[SW-1:0];
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_average = m_average_reg;

    `ABTM_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready)
    `ABTM_ASSERT_NXT(a_out_shown, aclk, aresetn, cmd.out_load, m_valid_reg)
    `ABTM_ASSERT_IMP(a_pos_in_block, aclk, aresetn, wr_en, 32'(pos) < W)
    `ABTM_ASSERT_IMP(a_row_sorted, aclk, aresetn, cmd.sum && (step_reg == '0), arr_reg[0] <= arr_reg[1])

endmodule

`default_nettype wire

/* rtl/core/adc_block_trimmed_mean_core.sv */
// An item that leaves its block open is written to its slot and returns its channel's
// held average; the item that completes a block is first loaded into the sort row,
// odd-even sorted, band-summed and divided. A new item is accepted only after the
// previous result has been loaded into the output register.
// Reset (aresetn low, synchronous): clears fill counts, held averages, skip to 5,
// and the handshake; the sample store is not cleared and needs no clearing pass.
`default_nettype none

module adc_block_trimmed_mean_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Configuration: skip_low register
    input  wire logic                         cfg_we,
    input  wire logic [abtm_pkg::SKIP_W-1:0]   cfg_wdata,
    // Input items
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [abtm_pkg::CHAN_W-1:0]   s_channel,
    input  wire logic [abtm_pkg::SAMPLE_W-1:0] s_sample,
    // Result items
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [abtm_pkg::SAMPLE_W-1:0] m_average
);

    // Skip count; user must have writes arrive only while block is idle (unchecked)
    logic [abtm_pkg::SKIP_W-1:0] skip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= abtm_pkg::SKIP_RESET;
        end else if (cfg_we) begin
            skip_reg <= cfg_wdata;
        end
    end

    abtm_pkg::abtm_cmd_t    cmd;
    abtm_pkg::abtm_status_t status;

    // Sequence each item: write its slot, and on a full block load the block
    // into the sort row, sort it, sum the trimmed band and divide by WINDOW/2
    abtm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Store, sort row, accumulator, divider and the output register that
    // lets the next item in while a result still waits
    abtm_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .skip_low  (skip_reg),
        .s_channel (s_channel),
        .s_sample  (s_sample),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_average (m_average)
    );

endmodule

`default_nettype wire

/* bench/tb_adc_block_trimmed_mean_core.sv */
// Self-checking bench for the per-channel trimmed-mean ADC filter core.
`default_nettype none

module tb_adc_block_trimmed_mean_core;

    localparam int WINDOW   = abtm_pkg::WINDOW;
    localparam int CHANNELS = abtm_pkg::CHANNELS;
    localparam int HALF_WIN = abtm_pkg::HALF_WIN;
    localparam int SAMPLE_W = abtm_pkg::SAMPLE_W;
    localparam int CHAN_W   = abtm_pkg::CHAN_W;
    localparam int SKIP_W   = abtm_pkg::SKIP_W;
    localparam logic [SKIP_W-1:0] SKIP_RESET = abtm_pkg::SKIP_RESET;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 16;
    // Extra wait after every pending result has come back.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int RUN_LIMIT     = 600000;

    // One pending result: the channel it belongs to and the mean it must carry.
    typedef struct {
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] average;
    } mean_entry_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [SKIP_W-1:0]   cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [CHAN_W-1:0]   s_channel;
    logic [SAMPLE_W-1:0] s_sample;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [SAMPLE_W-1:0] m_average;

    // Predictor state: sample blocks, fill levels, held means and the skip register.
    logic [SAMPLE_W-1:0] block_store [CHANNELS][WINDOW];
    int                  fill_level  [CHANNELS];
    logic [SAMPLE_W-1:0] held_mean   [CHANNELS];
    logic [SKIP_W-1:0]   skip_setting;

    mean_entry_t pending_means[$];

    bit no_idle;
    int errors;
    int items_sent;
    int means_checked;
    int blocks_done;
    int skip_writes;

    adc_block_trimmed_mean_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_channel (s_channel),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_average (m_average)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    // Stall the result side about one cycle in six, except in the no-idle stretch.
    always @(negedge aclk) begin
        m_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Store the sample, and when the block fills, sort it and take the mean of the
    // HALF_WIN samples that start skip places above the smallest. A skip that would
    // run past the top of the block saturates, so the largest HALF_WIN are summed.
    function automatic logic [SAMPLE_W-1:0] next_mean(input logic [CHAN_W-1:0] chan,
                                                      input logic [SAMPLE_W-1:0] smp);
        logic [SAMPLE_W-1:0] sorted [WINDOW];
        logic [SAMPLE_W-1:0] tmp;
        int start;
        int sum;
        int i;
        int j;
        begin
            // Absent channels change nothing and read back zero.
            if (int'(chan) >= CHANNELS)
                return '0;
            block_store[chan][fill_level[chan]] = smp;
            fill_level[chan]++;
            if (fill_level[chan] == WINDOW) begin
                for (i = 0; i < WINDOW; i++)
                    sorted[i] = block_store[chan][i];
                for (i = 1; i < WINDOW; i++) begin
                    tmp = sorted[i];
                    j = i - 1;
                    while (j >= 0 && sorted[j] > tmp) begin
                        sorted[j + 1] = sorted[j];
                        j--;
                    end
                    sorted[j + 1] = tmp;
                end
                start = int'(skip_setting);
                if (start > WINDOW - HALF_WIN)
                    start = WINDOW - HALF_WIN;
                sum = 0;
                for (i = 0; i < HALF_WIN; i++)
                    sum += int'(sorted[start + i]);
                held_mean[chan] = SAMPLE_W'(sum / HALF_WIN);
                fill_level[chan] = 0;
                blocks_done++;
            end
            return held_mean[chan];
        end
    endfunction

    // Uniform samples half the time, plus extremes, tiny and near-full values and a tight
    // cluster so that sorted blocks see runs of duplicates.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(2040, 2056));
            3:       return SAMPLE_W'($urandom_range(0, 15));
            4:       return SAMPLE_W'($urandom_range(4080, 4095));
            default: return SAMPLE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Compare every accepted result with the oldest pending mean.
    always @(posedge aclk) begin
        mean_entry_t exp_mean;
        if (aresetn && m_valid && m_ready) begin
            if (pending_means.size() == 0) begin
                $display("%0t: unexpected result: expected none, got average %0d",
                         $time, m_average);
                errors++;
            end else begin
                exp_mean = pending_means.pop_front();
                means_checked++;
                if (m_average !== exp_mean.average) begin
                    $display("%0t: average mismatch on channel %0d: expected %0d, got %0d",
                             $time, exp_mean.chan, exp_mean.average, m_average);
                    errors++;
                end
            end
        end
    end

    // Call at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_sample(input logic [CHAN_W-1:0] chan,
                               input logic [SAMPLE_W-1:0] smp);
        mean_entry_t entry;
        begin
            // Idle for a random gap with valid low.
            while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
            s_valid   <= 1'b1;
            s_channel <= chan;
            s_sample  <= smp;
            // Hold the item until the handshake completes.
            do
                @(posedge aclk);
            while (!s_ready);
            entry.chan    = chan;
            entry.average = next_mean(chan, smp);
            pending_means.push_back(entry);
            items_sent++;
            @(negedge aclk);
        end
    endtask

    // Drop valid, let every pending result come back, then wait out the pipeline.
    task automatic drain_results();
        int waited;
        begin
            s_valid <= 1'b0;
            waited = 0;
            while (pending_means.size() != 0 && waited < DRAIN_LIMIT) begin
                @(negedge aclk);
                waited++;
            end
            repeat (SETTLE_CYCLES) @(negedge aclk);
        end
    endtask

    // Write the skip register only with the block idle.
    task automatic write_skip(input logic [SKIP_W-1:0] value);
        begin
            drain_results();
            cfg_we    <= 1'b1;
            cfg_wdata <= value;
            @(negedge aclk);
            cfg_we <= 1'b0;
            skip_setting = value;
            skip_writes++;
            @(negedge aclk);
        end
    endtask

    task automatic run_random(input int count);
        logic [CHAN_W-1:0] hot;
        logic [CHAN_W-1:0] chan;
        int i;
        begin
            hot = CHAN_W'($urandom_range(0, CHANNELS - 1));
            for (i = 0; i < count; i++) begin
                // Favor one channel so its blocks complete often.
                if ($urandom_range(0, 1) != 0)
                    chan = hot;
                else
                    chan = CHAN_W'($urandom_range(0, CHANNELS - 1));
                send_sample(chan, pick_sample());
            end
        end
    endtask

    // Fill one block at the reset skip with extremes and alternating bit patterns,
    // then touch the remaining channels so they still read back zero.
    task automatic test_directed_extremes();
        logic [SAMPLE_W-1:0] pattern [WINDOW];
        int i;
        begin
            pattern = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd1, 12'd4094, 12'd2048,
                        12'd2047, 12'hAAA, 12'h555, 12'd4095, 12'd4095, 12'd4095, 12'd0,
                        12'd0, 12'd0, 12'd100, 12'd3000, 12'd4095, 12'd0};
            for (i = 0; i < WINDOW; i++)
                send_sample('0, pattern[i]);
            send_sample(CHAN_W'(1), '1);
            send_sample(CHAN_W'(2), 12'h555);
            send_sample(CHAN_W'(3), 12'hAAA);
        end
    endtask

    // Skip at zero, at the top of its range, at the saturation boundary and just past.
    task automatic test_skip_bounds();
        begin
            write_skip('0);
            run_random(200);
            write_skip('1);
            run_random(200);
            write_skip(SKIP_W'(WINDOW - HALF_WIN));
            run_random(150);
            write_skip(SKIP_W'(WINDOW - HALF_WIN + 1));
            run_random(100);
        end
    endtask

    // Random skips; one phase runs with no idling on either side.
    task automatic test_random_settings();
        int phase;
        begin
            for (phase = 0; phase < 4; phase++) begin
                write_skip(SKIP_W'($urandom_range(0, 15)));
                no_idle = (phase == 2);
                run_random(100);
            end
            no_idle = 1'b0;
            write_skip(SKIP_RESET);
            run_random(30);
        end
    endtask

    initial begin
        int i;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_channel = '0;
        s_sample  = '0;
        no_idle   = 1'b0;
        errors        = 0;
        items_sent    = 0;
        means_checked = 0;
        blocks_done   = 0;
        skip_writes   = 0;
        skip_setting  = SKIP_RESET;
        for (i = 0; i < CHANNELS; i++) begin
            fill_level[i] = 0;
            held_mean[i]  = '0;
        end
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_extremes();
        test_skip_bounds();
        test_random_settings();

        drain_results();
        if (pending_means.size() != 0) begin
            $display("%0t: %0d results never arrived: expected %0d more, got 0",
                     $time, pending_means.size(), pending_means.size());
            errors++;
        end
        $display("covered %0d items on %0d channels, %0d skip writes, %0d blocks completed",
                 items_sent, CHANNELS, skip_writes, blocks_done);
        $display("compared %0d results, %0d errors", means_checked, errors);
        if (errors == 0)
            $display("tb_adc_block_trimmed_mean_core: clean");
        else
            $display("tb_adc_block_trimmed_mean_core: errors");
        $finish;
    end

    // End a hung run.
    initial begin
        #(2 * CLK_HALF * RUN_LIMIT);
        $display("%0t: timeout with %0d results pending", $time, pending_means.size());
        $display("tb_adc_block_trimmed_mean_core: errors");
        $finish;
    end

endmodule

`default_nettype wire
